// ----- rtl/ipfc_pkg.sv -----
package ipfc_pkg;

	// Beat layout on the slave side (tdata) and the master side (tdata).
	localparam int S_TDATA_W = 96;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 200;
	localparam int SLOT_W    = 4;
	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 32;

	localparam logic [15:0]      ETH_IPV4  = 16'h0800;
	localparam logic [7:0]       PROTO_TCP = 8'd6;
	localparam logic [7:0]       PROTO_UDP = 8'd17;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	localparam logic REQ_PACKET = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	localparam logic [1:0] CLASS_OTHER = 2'd0;
	localparam logic [1:0] CLASS_TCP   = 2'd1;
	localparam logic [1:0] CLASS_UDP   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the accepted beat, clear the result
		logic count;       // bump the IP/TCP/UDP totals
		logic src_step;    // advance the source scan by one entry
		logic src_append;  // store a new source at the end of the table
		logic set_full;    // mark the pair as not stored
		logic d_base;      // compute the pair base of the current source
		logic d_used_load; // capture the destination fill count
		logic d_step;      // advance the destination scan by one entry
		logic pair_hit_wr; // raise the count of the matching pair
		logic d_append;    // store a new destination with a count of one
		logic rd_chk;      // read request: check the source slot
		logic rd_used;     // read request: check the destination slot
		logic rd_data;     // read request: capture the pair
		logic out_load;    // move the result into the output register
	} ipfc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_read;
		logic in_ipv4;
		logic used_zero;
		logic src_full;
		logic src_hit;
		logic src_last;
		logic dused_zero;
		logic dst_hit;
		logic dst_last;
		logic dst_full;
		logic out_free;
	} ipfc_sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ----- rtl/ipfc_ram.sv -----
module ipfc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ipfc_dp.sv -----
module ipfc_dp #(
	parameter int SRC_ENTRIES = 16,
	parameter int DST_PER_SRC = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ipfc_pkg::ipfc_cmd_t              cmd,
	output ipfc_pkg::ipfc_sts_t              sts,
	input  logic [ipfc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [ipfc_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ipfc_pkg::M_TDATA_W-1:0]   m_tdata
);

	import ipfc_pkg::*;

	localparam int SA    = (SRC_ENTRIES > 1) ? $clog2(SRC_ENTRIES) : 1;
	localparam int UW    = $clog2(SRC_ENTRIES + 1);
	localparam int DW    = $clog2(DST_PER_SRC + 1);
	localparam int PAIRS = SRC_ENTRIES * DST_PER_SRC;
	localparam int PA    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int CW    = (UW > SLOT_W) ? UW : SLOT_W;
	localparam int CDW   = (DW > SLOT_W) ? DW : SLOT_W;
	localparam int PW    = CNT_W + ADDR_W;

	// Incoming beat fields.
	logic              in_req;
	logic [15:0]       in_eth;
	logic [7:0]        in_proto;
	logic [ADDR_W-1:0] in_src;
	logic [ADDR_W-1:0] in_dst;
	logic [SLOT_W-1:0] in_rs;
	logic [SLOT_W-1:0] in_rd;

	assign in_req   = s_tuser[0];
	assign in_eth   = s_tdata[15:0];
	assign in_proto = s_tdata[23:16];
	assign in_src   = s_tdata[55:24];
	assign in_dst   = s_tdata[87:56];
	assign in_rs    = s_tdata[91:88];
	assign in_rd    = s_tdata[95:92];

	// Item registers and result.
	logic              ip_q;
	logic [1:0]        cls_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] dst_q;
	logic [SLOT_W-1:0] rs_q;
	logic [SLOT_W-1:0] rd_q;
	logic              full_q;
	logic [CNT_W-1:0]  count_q;
	logic              valid_q;
	logic [ADDR_W-1:0] esrc_q;
	logic [ADDR_W-1:0] edst_q;

	// Table bookkeeping.
	logic [UW-1:0]     used_q;
	logic [SA-1:0]     sidx_q;
	logic [DW-1:0]     didx_q;
	logic [DW-1:0]     dused_q;
	logic [PA-1:0]     base_q;
	logic [CNT_W-1:0]  ip_cnt_q;
	logic [CNT_W-1:0]  tcp_cnt_q;
	logic [CNT_W-1:0]  udp_cnt_q;

	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// Memory ports.
	logic [SA-1:0]     src_raddr;
	logic [ADDR_W-1:0] src_rdata;
	logic [SA-1:0]     du_raddr;
	logic [SA-1:0]     du_waddr;
	logic [DW-1:0]     du_wdata;
	logic              du_we;
	logic [DW-1:0]     du_rdata;
	logic [PA-1:0]     pair_raddr;
	logic [PA-1:0]     pair_waddr;
	logic [PW-1:0]     pair_wdata;
	logic              pair_we;
	logic [PW-1:0]     pair_rdata;
	logic [PA-1:0]     pair_off;
	logic [CNT_W-1:0]  pair_inc;

	logic [SA-1:0]     rs_sa;
	logic [SA-1:0]     mul_sel;
	logic [PA-1:0]     base_next;
	logic              rs_ok;
	logic              rd_ok;
	logic [1:0]        in_cls;
	logic              in_ip;

	assign rs_sa     = SA'(rs_q);
	assign mul_sel   = cmd.rd_chk ? rs_sa : sidx_q;
	assign base_next = PA'(mul_sel * DST_PER_SRC);
	assign rs_ok     = CW'(rs_q) < CW'(used_q);
	assign rd_ok     = CDW'(rd_q) < CDW'(du_rdata);
	assign pair_inc  = sat_inc(pair_rdata[PW-1:ADDR_W]);

	assign in_ip = (in_req == REQ_PACKET) && (in_eth == ETH_IPV4);

	always_comb begin
		if (!in_ip) begin
			in_cls = CLASS_OTHER;
		end else if (in_proto == PROTO_TCP) begin
			in_cls = CLASS_TCP;
		end else if (in_proto == PROTO_UDP) begin
			in_cls = CLASS_UDP;
		end else begin
			in_cls = CLASS_OTHER;
		end
	end

	// Source table.
	assign src_raddr = cmd.rd_chk ? rs_sa : (cmd.src_step ? sidx_q + SA'(1) : sidx_q);

	ipfc_ram #(.WIDTH(ADDR_W), .DEPTH(SRC_ENTRIES)) u_src_ram (
		.clk   (clk),
		.we    (cmd.src_append),
		.waddr (SA'(used_q)),
		.wdata (src_q),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	// Destination fill counts. A new source writes its count to zero, so no
	// clearing is needed: only slots below the source count ever affect a result.
	assign du_raddr = cmd.rd_chk ? rs_sa : sidx_q;
	assign du_we    = cmd.src_append | cmd.d_append;
	assign du_waddr = cmd.src_append ? SA'(used_q) : sidx_q;
	assign du_wdata = cmd.src_append ? '0 : dused_q + DW'(1);

	ipfc_ram #(.WIDTH(DW), .DEPTH(SRC_ENTRIES)) u_dused_ram (
		.clk   (clk),
		.we    (du_we),
		.waddr (du_waddr),
		.wdata (du_wdata),
		.raddr (du_raddr),
		.rdata (du_rdata)
	);

	// Pair store: count in the upper half, destination in the lower half.
	always_comb begin
		if (cmd.rd_used) begin
			pair_off = PA'(rd_q);
		end else if (cmd.d_step) begin
			pair_off = PA'(didx_q) + PA'(1);
		end else begin
			pair_off = PA'(didx_q);
		end
	end

	assign pair_raddr = base_q + pair_off;
	assign pair_waddr = base_q + (cmd.d_append ? PA'(dused_q) : PA'(didx_q));
	assign pair_we    = cmd.pair_hit_wr | cmd.d_append;
	assign pair_wdata = cmd.d_append ? {CNT_W'(1), dst_q} : {pair_inc, dst_q};

	ipfc_ram #(.WIDTH(PW), .DEPTH(PAIRS)) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.raddr (pair_raddr),
		.rdata (pair_rdata)
	);

	// Control state: source count, totals, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			ip_cnt_q   <= '0;
			tcp_cnt_q  <= '0;
			udp_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.src_append) begin
				used_q <= used_q + UW'(1);
			end
			if (cmd.count) begin
				ip_cnt_q <= sat_inc(ip_cnt_q);
				if (cls_q == CLASS_TCP) begin
					tcp_cnt_q <= sat_inc(tcp_cnt_q);
				end
				if (cls_q == CLASS_UDP) begin
					udp_cnt_q <= sat_inc(udp_cnt_q);
				end
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ip_q    <= in_ip;
			cls_q   <= in_cls;
			src_q   <= in_src;
			dst_q   <= in_dst;
			rs_q    <= in_rs;
			rd_q    <= in_rd;
			sidx_q  <= '0;
			full_q  <= 1'b0;
			count_q <= '0;
			valid_q <= 1'b0;
			esrc_q  <= '0;
			edst_q  <= '0;
		end
		if (cmd.src_step) begin
			sidx_q <= sidx_q + SA'(1);
		end
		if (cmd.src_append) begin
			sidx_q <= SA'(used_q);
		end
		if (cmd.set_full) begin
			full_q <= 1'b1;
		end
		if (cmd.d_base || cmd.rd_chk) begin
			base_q <= base_next;
			didx_q <= '0;
		end
		if (cmd.d_used_load) begin
			dused_q <= du_rdata;
		end
		if (cmd.d_step) begin
			didx_q <= didx_q + DW'(1);
		end
		if (cmd.pair_hit_wr) begin
			count_q <= pair_inc;
		end
		if (cmd.d_append) begin
			count_q <= CNT_W'(1);
		end
		if (cmd.rd_chk) begin
			valid_q <= rs_ok;
		end
		if (cmd.rd_used) begin
			valid_q <= valid_q && rd_ok;
			if (valid_q && rd_ok) begin
				esrc_q <= src_rdata;
			end
		end
		if (cmd.rd_data && valid_q) begin
			edst_q  <= pair_rdata[ADDR_W-1:0];
			count_q <= pair_rdata[PW-1:ADDR_W];
		end
		if (cmd.out_load) begin
			m_tdata_q <= {3'b000, edst_q, esrc_q, valid_q, udp_cnt_q, tcp_cnt_q,
				ip_cnt_q, count_q, full_q, cls_q, ip_q};
		end
	end

	assign sts.in_read    = (in_req == REQ_READ);
	assign sts.in_ipv4    = (in_eth == ETH_IPV4);
	assign sts.used_zero  = (used_q == '0);
	assign sts.src_full   = (used_q == UW'(SRC_ENTRIES));
	assign sts.src_hit    = (src_rdata == src_q);
	assign sts.src_last   = ((UW'(sidx_q) + UW'(1)) == used_q);
	assign sts.dused_zero = (du_rdata == '0);
	assign sts.dst_hit    = (pair_rdata[ADDR_W-1:0] == dst_q);
	assign sts.dst_last   = ((didx_q + DW'(1)) == dused_q);
	assign sts.dst_full   = (dused_q == DW'(DST_PER_SRC));
	assign sts.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- rtl/ipfc_ctrl.sv -----
module ipfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  ipfc_pkg::ipfc_sts_t sts,
	output ipfc_pkg::ipfc_cmd_t cmd
);

	import ipfc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SRC_SCAN,
		ST_SRC_MISS,
		ST_DST_BASE,
		ST_DST_USED,
		ST_DST_SCAN,
		ST_DST_MISS,
		ST_RD_CHK,
		ST_RD_USED,
		ST_RD_DATA,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.in_read) begin
						state_nxt = ST_RD_CHK;
					end else if (sts.in_ipv4) begin
						state_nxt = ST_COUNT;
					end else begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_nxt = sts.used_zero ? ST_SRC_MISS : ST_SRC_SCAN;
			end
			ST_SRC_SCAN: begin
				if (sts.src_hit) begin
					state_nxt = ST_DST_BASE;
				end else if (sts.src_last) begin
					state_nxt = ST_SRC_MISS;
				end else begin
					cmd.src_step = 1'b1;
				end
			end
			ST_SRC_MISS: begin
				if (sts.src_full) begin
					cmd.set_full = 1'b1;
					state_nxt    = ST_FIN;
				end else begin
					cmd.src_append = 1'b1;
					state_nxt      = ST_DST_BASE;
				end
			end
			ST_DST_BASE: begin
				cmd.d_base = 1'b1;
				state_nxt  = ST_DST_USED;
			end
			ST_DST_USED: begin
				cmd.d_used_load = 1'b1;
				state_nxt       = sts.dused_zero ? ST_DST_MISS : ST_DST_SCAN;
			end
			ST_DST_SCAN: begin
				if (sts.dst_hit) begin
					cmd.pair_hit_wr = 1'b1;
					state_nxt       = ST_FIN;
				end else if (sts.dst_last) begin
					state_nxt = ST_DST_MISS;
				end else begin
					cmd.d_step = 1'b1;
				end
			end
			ST_DST_MISS: begin
				if (sts.dst_full) begin
					cmd.set_full = 1'b1;
				end else begin
					cmd.d_append = 1'b1;
				end
				state_nxt = ST_FIN;
			end
			ST_RD_CHK: begin
				cmd.rd_chk = 1'b1;
				state_nxt  = ST_RD_USED;
			end
			ST_RD_USED: begin
				cmd.rd_used = 1'b1;
				state_nxt   = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				cmd.rd_data = 1'b1;
				state_nxt   = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/ip_pair_flow_counter_core.sv -----
// Channel   Dir  Signals                     Contents
// slave     in   s_tvalid s_tready s_tdata   one request beat: packet header or table read
//                s_tuser                     request kind
// master    out  m_tvalid m_tready m_tdata   one result beat per request
//
// Requests are handled one at a time. An IPv4 packet scans the source table and then that
// source's destinations; a full source table ends it after the source scan. The single
// read port of each memory limits the scans to comparing one entry a cycle.
// Reset clears the source count, the totals and the output valid; the tables need no clearing.
// The next request is accepted while a result waits; a stalled result holds it in its last cycle.
module ip_pair_flow_counter_core #(
	parameter int SRC_ENTRIES = 16,
	parameter int DST_PER_SRC = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// From bit 0: eth_type[15:0], ip_proto[7:0], src_addr[31:0], dst_addr[31:0],
	// read_src_slot[3:0], read_dst_slot[3:0].
	input  logic [ipfc_pkg::S_TDATA_W-1:0] s_tdata,
	// From bit 0: req_type (0 packet header, 1 table read).
	input  logic [ipfc_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// From bit 0: is_ip, proto_class[1:0], table_full, pair_count[31:0], ip_total[31:0],
	// tcp_total[31:0], udp_total[31:0], entry_valid, entry_src[31:0], entry_dst[31:0],
	// then three zero bits.
	output logic [ipfc_pkg::M_TDATA_W-1:0] m_tdata
);

	import ipfc_pkg::*;

	ipfc_cmd_t cmd;
	ipfc_sts_t sts;

	// The controller walks each request through its steps: classify and count, scan the
	// source table, append a new source, scan that source's destinations, then bump the
	// matching pair, append it or flag a full table. Reads go through three fixed memory steps.
	ipfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the tables, the totals and the output register.
	ipfc_dp #(
		.SRC_ENTRIES (SRC_ENTRIES),
		.DST_PER_SRC (DST_PER_SRC)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- rtl/ipfc_checker.sv -----
module ipfc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ipfc_pkg::M_TDATA_W-1:0] m_tdata
);

	import ipfc_pkg::*;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// One request at a time: the slave side is closed in the cycle after a beat is accepted.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in progress");

	// Anything that is not an IPv4 packet carries no class and no full flag.
	a_non_ip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == CLASS_OTHER && !m_tdata[3])
		else $error("class or full flag on a non-IPv4 result");

	// A valid read entry is never a packet result and always has a count.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[132] |-> !m_tdata[0] && m_tdata[35:4] != '0)
		else $error("inconsistent read entry");

	// A pair that was not stored reports no count.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[35:4] == '0)
		else $error("table full result with a pair count");

endmodule

bind ip_pair_flow_counter_core ipfc_checker u_ipfc_checker (.*);
